>>> src/lgtr_pkg.sv
// Shared definitions for the LDA topic resampler: register codes, reset
// values, fixed field widths and the weight unit status word.
// No dependencies.
package lgtr_pkg;

   localparam int DEF_MAX_TOPICS  = 64;
   localparam int DEF_MAX_DOCS    = 1024;
   localparam int DEF_MAX_VOCAB   = 4096;
   localparam int DEF_COUNT_WIDTH = 20;

   localparam int WEIGHT_W   = 48;
   localparam int RANDOM_W   = 24;
   localparam int DOC_W      = 10;
   localparam int WORD_W     = 12;
   localparam int TOPIC_W    = 6;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int VB_W       = 29;

   localparam logic [CSR_IDX_W-1:0] CSR_TOPIC_COUNT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA        = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOCAB       = 8'd3;

   localparam logic [6:0]  RST_TOPIC_COUNT = 7'd16;
   localparam logic [15:0] RST_ALPHA       = 16'd128;
   localparam logic [15:0] RST_BETA        = 16'd26;
   localparam logic [12:0] RST_VOCAB       = 13'd4096;

   localparam logic FUNC_ADD      = 1'b0;
   localparam logic FUNC_RESAMPLE = 1'b1;

   typedef struct packed {
      logic                done;
      logic [WEIGHT_W-1:0] quotient;
   } wu_status_type;

endpackage

>>> src/lda_gibbs_topic_resampler_unit.sv
// Top level of the LDA collapsed Gibbs topic resampler: count memories,
// weight scratch, sequencer and stream ports.
// Depends on lgtr_pkg, lgtr_ram and lgtr_weight_unit.
//
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser func, tdata token
// rsp      out        rsp_tvalid/rsp_tready  tdata new_topic, tuser count_error
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// An add word passes index reduction, count read, count write and the result
// register, with one more reduction step for each wrap of an index that exceeds
// its table. A resample word removes the old topic's counts, has the weight unit
// weigh each of the K active topics (MCH multiply chunks, 2 at the default count
// width, then the one-bit-a-cycle divide), draws a threshold, scans the weights
// and counts the chosen topic before its result. After reset a clearing pass
// zeroes the count memories; no word is accepted meanwhile. A stalled result
// holds the block in its final step until taken.
module lda_gibbs_topic_resampler_unit import lgtr_pkg::*; #(
   parameter int MAX_TOPICS  = DEF_MAX_TOPICS,
   parameter int MAX_DOCS    = DEF_MAX_DOCS,
   parameter int MAX_VOCAB   = DEF_MAX_VOCAB,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // doc_index [9:0], word_id [21:10], old_topic [27:22], random_value [51:28]
   input  logic [55:0]           req_tdata,
   // func [0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // new_topic [5:0]
   output logic [7:0]            rsp_tdata,
   // count_error [0]
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int TIW  = $clog2(MAX_TOPICS);
   localparam int KW   = TIW + 1;
   localparam int DTD  = MAX_DOCS * MAX_TOPICS;
   localparam int TWD  = MAX_TOPICS * MAX_VOCAB;
   localparam int DTA  = $clog2(DTD);
   localparam int TWA  = $clog2(TWD);
   localparam int DOCA = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
   localparam int TTW  = COUNT_WIDTH + 4;
   localparam int TOTW = WEIGHT_W + KW;
   localparam int AW   = COUNT_WIDTH + 9;
   localparam int DW   = ((COUNT_WIDTH + 12 > VB_W) ? COUNT_WIDTH + 12 : VB_W) + 1;
   localparam int CLRD1 = (TWD > DTD) ? TWD : DTD;
   localparam int CLRD  = (CLRD1 > MAX_DOCS) ? CLRD1 : MAX_DOCS;
   localparam int CLRW  = $clog2(CLRD + 1);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [TTW-1:0]         TOT_MAX = '1;

   typedef enum logic [12:0] {
      S_CLEAR    = 13'b0000000000001,
      S_IDLE     = 13'b0000000000010,
      S_MOD      = 13'b0000000000100,
      S_CNT_RD   = 13'b0000000001000,
      S_CNT_WR   = 13'b0000000010000,
      S_W_RD     = 13'b0000000100000,
      S_W_GO     = 13'b0000001000000,
      S_W_WAIT   = 13'b0000010000000,
      S_THR_HI   = 13'b0000100000000,
      S_THR_LO   = 13'b0001000000000,
      S_SCAN_RD  = 13'b0010000000000,
      S_SCAN_CMP = 13'b0100000000000,
      S_DONE     = 13'b1000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [6:0]           topic_count_ff;
   logic [15:0]          alpha_ff, beta_ff;
   logic [12:0]          vocab_ff;
   logic [VB_W-1:0]      vb_ff;

   logic                 func_ff, func_in;
   logic [DOC_W-1:0]     d_ff, d_in;
   logic [WORD_W-1:0]    w_ff, w_in;
   logic [TOPIC_W-1:0]   t_ff, t_in;
   logic [RANDOM_W-1:0]  r_ff, r_in;
   logic                 up_ff, up_in;
   logic [TIW-1:0]       tgt_ff, tgt_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [KW-1:0]        kk_ff, kk_in;
   logic [TOTW-1:0]      total_ff, total_in;
   logic [TOTW-1:0]      thr_ff, thr_in;
   logic [TOTW-1:0]      run_ff, run_in;
   logic                 err_ff, err_in;
   logic [CLRW-1:0]      clr_ff, clr_in;
   logic                 out_valid_ff, out_valid_in;
   logic [TOPIC_W-1:0]   out_topic_ff, out_topic_in;
   logic                 out_err_ff, out_err_in;

   logic [TIW-1:0]          sel_topic;
   logic [DTA-1:0]          dt_addr;
   logic [TWA-1:0]          tw_addr;
   logic                    dt_we, tw_we, tt_we, dtot_we, ws_we;
   logic [COUNT_WIDTH-1:0]  dt_wdata, tw_wdata, dtot_wdata;
   logic [TTW-1:0]          tt_wdata;
   logic [COUNT_WIDTH-1:0]  dt_rdata, tw_rdata, dtot_rdata;
   logic [TTW-1:0]          tt_rdata;
   logic [WEIGHT_W-1:0]     ws_rdata;
   logic [DTA-1:0]          dt_ram_addr;
   logic [TWA-1:0]          tw_ram_addr;
   logic [TIW-1:0]          tt_ram_addr;
   logic [DOCA-1:0]         dtot_ram_addr;
   logic                    clearing;

   logic                    wu_start;
   logic [AW-1:0]           wu_a, wu_b;
   logic [DW-1:0]           wu_den;
   wu_status_type           wu_status;
   logic [8:0]              tc_clamp;
   logic [TOTW-1:0]         run_next;

   assign clearing   = (state_ff == S_CLEAR);
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_topic_ff};
   assign rsp_tuser  = out_err_ff;

   // Weight pass walks the topic counter; the count updates use the target.
   assign sel_topic = (state_ff == S_W_RD) ? k_ff[TIW-1:0] : tgt_ff;
   assign dt_addr   = DTA'(DTA'(d_ff) * DTA'(MAX_TOPICS) + DTA'(sel_topic));
   assign tw_addr   = TWA'(TWA'(sel_topic) * TWA'(MAX_VOCAB) + TWA'(w_ff));

   assign dt_ram_addr   = clearing ? clr_ff[DTA-1:0] : dt_addr;
   assign tw_ram_addr   = clearing ? clr_ff[TWA-1:0] : tw_addr;
   assign tt_ram_addr   = clearing ? clr_ff[TIW-1:0] : sel_topic;
   assign dtot_ram_addr = clearing ? clr_ff[DOCA-1:0] : DOCA'(d_ff);

   assign wu_a   = AW'({tw_rdata, 8'b0}) + AW'(beta_ff);
   assign wu_b   = AW'({dt_rdata, 8'b0}) + AW'(alpha_ff);
   assign wu_den = DW'({tt_rdata, 8'b0}) + DW'(vb_ff);
   assign wu_start = (state_ff == S_W_GO);

   assign tc_clamp = (topic_count_ff == 7'd0) ? 9'd1 :
                     ((9'(topic_count_ff) > 9'(MAX_TOPICS)) ? 9'(MAX_TOPICS)
                                                            : 9'(topic_count_ff));
   assign run_next = run_ff + TOTW'(ws_rdata);

   lgtr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DTD)) u_doc_topic (
      .clock(clock), .we(dt_we), .addr(dt_ram_addr), .wdata(dt_wdata), .rdata(dt_rdata)
   );
   lgtr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TWD)) u_topic_word (
      .clock(clock), .we(tw_we), .addr(tw_ram_addr), .wdata(tw_wdata), .rdata(tw_rdata)
   );
   lgtr_ram #(.WIDTH(TTW), .DEPTH(MAX_TOPICS)) u_topic_tot (
      .clock(clock), .we(tt_we), .addr(tt_ram_addr), .wdata(tt_wdata), .rdata(tt_rdata)
   );
   lgtr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_DOCS)) u_doc_tot (
      .clock(clock), .we(dtot_we), .addr(dtot_ram_addr), .wdata(dtot_wdata),
      .rdata(dtot_rdata)
   );
   lgtr_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_TOPICS)) u_scratch (
      .clock(clock), .we(ws_we), .addr(k_ff[TIW-1:0]), .wdata(wu_status.quotient),
      .rdata(ws_rdata)
   );

   lgtr_weight_unit #(.COUNT_WIDTH(COUNT_WIDTH), .AW(AW), .DW(DW)) u_weight (
      .clock(clock), .reset(reset), .start(wu_start), .a_val(wu_a), .b_val(wu_b),
      .den_val(wu_den), .status(wu_status)
   );

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      d_in         = d_ff;
      w_in         = w_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      up_in        = up_ff;
      tgt_in       = tgt_ff;
      k_in         = k_ff;
      kk_in        = kk_ff;
      total_in     = total_ff;
      thr_in       = thr_ff;
      run_in       = run_ff;
      err_in       = err_ff;
      clr_in       = clr_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_topic_in = out_topic_ff;
      out_err_in   = out_err_ff;
      dt_we        = 1'b0;
      tw_we        = 1'b0;
      tt_we        = 1'b0;
      dtot_we      = 1'b0;
      ws_we        = 1'b0;
      dt_wdata     = '0;
      tw_wdata     = '0;
      tt_wdata     = '0;
      dtot_wdata   = '0;
      case (state_ff)
         S_CLEAR: begin
            dt_we   = (CLRW'(clr_ff) < CLRW'(DTD));
            tw_we   = (CLRW'(clr_ff) < CLRW'(TWD));
            tt_we   = (CLRW'(clr_ff) < CLRW'(MAX_TOPICS));
            dtot_we = (CLRW'(clr_ff) < CLRW'(MAX_DOCS));
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == CLRW'(CLRD - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               d_in     = req_tdata[9:0];
               w_in     = req_tdata[21:10];
               t_in     = req_tdata[27:22];
               r_in     = req_tdata[51:28];
               err_in   = 1'b0;
               kk_in    = KW'(tc_clamp);
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            // Indices beyond the table sizes wrap, one subtraction a cycle.
            if (17'(d_ff) >= 17'(MAX_DOCS)) begin
               d_in = d_ff - DOC_W'(MAX_DOCS);
            end
            if (17'(w_ff) >= 17'(MAX_VOCAB)) begin
               w_in = w_ff - WORD_W'(MAX_VOCAB);
            end
            if (9'(t_ff) >= 9'(MAX_TOPICS)) begin
               t_in = t_ff - TOPIC_W'(MAX_TOPICS);
            end
            if (17'(d_ff) < 17'(MAX_DOCS) && 17'(w_ff) < 17'(MAX_VOCAB) &&
                9'(t_ff) < 9'(MAX_TOPICS)) begin
               tgt_in   = TIW'(t_ff);
               up_in    = (func_ff == FUNC_ADD);
               state_in = S_CNT_RD;
            end
         end
         S_CNT_RD: begin
            state_in = S_CNT_WR;
         end
         S_CNT_WR: begin
            dt_we   = 1'b1;
            tw_we   = 1'b1;
            tt_we   = 1'b1;
            dtot_we = 1'b1;
            if (up_ff) begin
               dt_wdata   = (dt_rdata == CNT_MAX) ? CNT_MAX : dt_rdata + 1'b1;
               tw_wdata   = (tw_rdata == CNT_MAX) ? CNT_MAX : tw_rdata + 1'b1;
               tt_wdata   = (tt_rdata == TOT_MAX) ? TOT_MAX : tt_rdata + 1'b1;
               dtot_wdata = (dtot_rdata == CNT_MAX) ? CNT_MAX : dtot_rdata + 1'b1;
               err_in = err_ff || dt_rdata == CNT_MAX || tw_rdata == CNT_MAX ||
                        tt_rdata == TOT_MAX || dtot_rdata == CNT_MAX;
               state_in = S_DONE;
            end else begin
               dt_wdata   = (dt_rdata == '0) ? '0 : dt_rdata - 1'b1;
               tw_wdata   = (tw_rdata == '0) ? '0 : tw_rdata - 1'b1;
               tt_wdata   = (tt_rdata == '0) ? '0 : tt_rdata - 1'b1;
               dtot_wdata = (dtot_rdata == '0) ? '0 : dtot_rdata - 1'b1;
               err_in = err_ff || dt_rdata == '0 || tw_rdata == '0 ||
                        tt_rdata == '0 || dtot_rdata == '0;
               k_in     = '0;
               total_in = '0;
               state_in = S_W_RD;
            end
         end
         S_W_RD: begin
            state_in = S_W_GO;
         end
         S_W_GO: begin
            state_in = S_W_WAIT;
         end
         S_W_WAIT: begin
            if (wu_status.done) begin
               ws_we    = 1'b1;
               total_in = total_ff + TOTW'(wu_status.quotient);
               k_in     = k_ff + 1'b1;
               if (k_ff + 1'b1 == kk_ff) begin
                  state_in = S_THR_HI;
               end else begin
                  state_in = S_W_RD;
               end
            end
         end
         S_THR_HI: begin
            thr_in   = TOTW'((total_ff >> RANDOM_W) * r_ff);
            state_in = S_THR_LO;
         end
         S_THR_LO: begin
            thr_in   = thr_ff + TOTW'((48'(total_ff[RANDOM_W-1:0]) * 48'(r_ff)) >> RANDOM_W);
            k_in     = '0;
            run_in   = '0;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            run_in = run_next;
            if (run_next > thr_ff) begin
               tgt_in   = k_ff[TIW-1:0];
               up_in    = 1'b1;
               state_in = S_CNT_RD;
            end else if (k_ff + 1'b1 == kk_ff) begin
               tgt_in   = k_ff[TIW-1:0];
               up_in    = 1'b1;
               state_in = S_CNT_RD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_topic_in = TOPIC_W'(tgt_ff);
               out_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         out_valid_ff   <= 1'b0;
         topic_count_ff <= RST_TOPIC_COUNT;
         alpha_ff       <= RST_ALPHA;
         beta_ff        <= RST_BETA;
         vocab_ff       <= RST_VOCAB;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_TOPIC_COUNT: topic_count_ff <= csr_data[6:0];
               CSR_ALPHA:       alpha_ff       <= csr_data;
               CSR_BETA:        beta_ff        <= csr_data;
               CSR_VOCAB:       vocab_ff       <= csr_data[12:0];
               default: begin
               end
            endcase
         end
      end
      vb_ff        <= vocab_ff * beta_ff;
      func_ff      <= func_in;
      d_ff         <= d_in;
      w_ff         <= w_in;
      t_ff         <= t_in;
      r_ff         <= r_in;
      up_ff        <= up_in;
      tgt_ff       <= tgt_in;
      k_ff         <= k_in;
      kk_ff        <= kk_in;
      total_ff     <= total_in;
      thr_ff       <= thr_in;
      run_ff       <= run_in;
      err_ff       <= err_in;
      out_topic_ff <= out_topic_in;
      out_err_ff   <= out_err_in;
   end

endmodule

>>> src/lgtr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module lgtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

>>> src/lgtr_weight_unit.sv
// Iterative weight unit: chunked multiply of the two count terms, then a
// saturating restoring divide by the topic denominator, one bit a cycle.
// Depends on lgtr_pkg.
module lgtr_weight_unit import lgtr_pkg::*; #(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int AW = COUNT_WIDTH + 9,
   parameter int DW = ((COUNT_WIDTH + 12 > VB_W) ? COUNT_WIDTH + 12 : VB_W) + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AW-1:0] a_val,
   input  logic [AW-1:0] b_val,
   input  logic [DW-1:0] den_val,
   output wu_status_type status
);

   localparam int MCH  = (AW + 15) / 16;
   localparam int BW   = MCH * 16;
   localparam int PW   = 2 * AW;
   localparam int NW   = PW + 8;
   localparam int CW   = (NW > DW + WEIGHT_W) ? NW : DW + WEIGHT_W;
   localparam int CNTW = $clog2(WEIGHT_W + 1);

   typedef enum logic [3:0] {
      WU_IDLE = 4'b0001,
      WU_MUL  = 4'b0010,
      WU_CHK  = 4'b0100,
      WU_DIV  = 4'b1000
   } wu_state_type;

   wu_state_type        state_ff, state_in;
   logic [AW-1:0]       a_ff, a_in;
   logic [BW-1:0]       b_ff, b_in;
   logic [DW-1:0]       den_ff, den_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [WEIGHT_W-1:0] bits_ff, bits_in;
   logic [WEIGHT_W-1:0] q_ff, q_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic [AW+15:0]      pp;
   logic [CW-1:0]       num_c;
   logic [CW-1:0]       lim_c;
   logic [DW:0]         r2;

   assign pp    = a_ff * b_ff[BW-1 -: 16];
   assign num_c = CW'({prod_ff, 8'b0});
   assign lim_c = CW'({den_ff, {WEIGHT_W{1'b0}}});
   assign r2    = {rem_ff, bits_ff[WEIGHT_W-1]};

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      den_in   = den_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      bits_in  = bits_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         WU_IDLE: begin
            if (start) begin
               a_in     = a_val;
               b_in     = BW'(b_val);
               den_in   = den_val;
               prod_in  = '0;
               cnt_in   = '0;
               state_in = WU_MUL;
            end
         end
         WU_MUL: begin
            // Top chunk of b first, so the running product shifts up.
            prod_in = PW'({prod_ff, 16'b0}) + PW'(pp);
            b_in    = b_ff << 16;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(MCH - 1)) begin
               state_in = WU_CHK;
            end
         end
         WU_CHK: begin
            if (den_ff == '0 || num_c >= lim_c) begin
               q_in     = '1;
               done_in  = 1'b1;
               state_in = WU_IDLE;
            end else begin
               rem_in   = DW'(num_c >> WEIGHT_W);
               bits_in  = num_c[WEIGHT_W-1:0];
               q_in     = '0;
               cnt_in   = '0;
               state_in = WU_DIV;
            end
         end
         WU_DIV: begin
            if (r2 >= {1'b0, den_ff}) begin
               rem_in = DW'(r2 - {1'b0, den_ff});
               q_in   = {q_ff[WEIGHT_W-2:0], 1'b1};
            end else begin
               rem_in = DW'(r2);
               q_in   = {q_ff[WEIGHT_W-2:0], 1'b0};
            end
            bits_in = bits_ff << 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(WEIGHT_W - 1)) begin
               done_in  = 1'b1;
               state_in = WU_IDLE;
            end
         end
         default: begin
            state_in = WU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      den_ff  <= den_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = q_ff;

endmodule

>>> tb/sv/tb_lda_gibbs_topic_resampler_unit.sv
// Testbench for lda_gibbs_topic_resampler_unit: streams add and resample words,
// predicts each topic choice from its own copy of the count tables and checks it.
// Depends on lgtr_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_lda_gibbs_topic_resampler_unit;
   import lgtr_pkg::*;

   localparam logic [47:0] WEIGHT_SAT = {48{1'b1}};

   typedef struct packed {
      logic [5:0] topic;
      logic       err;
   } topic_result_type;

   typedef struct {
      logic [9:0]  doc;
      logic [11:0] word;
      logic [5:0]  topic;
   } token_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Model copy of the count tables and registers.
   logic [19:0] doc_topic_cnt [65536];
   logic [19:0] topic_word_cnt [262144];
   logic [23:0] topic_total [64];
   logic [19:0] doc_total [1024];
   logic [6:0]  cfg_topics;
   logic [15:0] cfg_alpha;
   logic [15:0] cfg_beta;
   logic [12:0] cfg_vocab;

   topic_result_type expected_topics [$];
   token_type        live_tokens [$];
   int               mismatches = 0;
   int               burst_left = 0;
   int               stall_mode = 0;

   lda_gibbs_topic_resampler_unit dut (.*);

   always #5 clock = ~clock;

   // Receiver stall pattern: mode 0 never stalls, 1 stalls often, 2 holds long stalls.
   int stall_cnt = 0;
   always @(posedge clock) begin
      if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (stall_mode == 1 && $urandom_range(0, 2) == 0) begin
         stall_cnt <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
         stall_cnt <= $urandom_range(10, 60);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_topics.size() == 0) begin
            $display("%0t: unexpected result topic=%0d err=%0d", $time, rsp_tdata[5:0],
                     rsp_tuser);
            mismatches++;
         end else begin
            topic_result_type exp_r;
            exp_r = expected_topics.pop_front();
            if (rsp_tdata !== {2'b00, exp_r.topic}) begin
               $display("%0t: new_topic expected %0d actual %0d", $time, exp_r.topic,
                        rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser !== exp_r.err) begin
               $display("%0t: count_error expected %0d actual %0d", $time, exp_r.err,
                        rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   function automatic bit change_counts(logic [9:0] d, logic [11:0] w, logic [5:0] t,
                                        bit up);
      int  dt_i;
      int  tw_i;
      bit  e;
      dt_i = d * 64 + t;
      tw_i = t * 4096 + w;
      e = 1'b0;
      if (up) begin
         if (&doc_topic_cnt[dt_i]) e = 1'b1; else doc_topic_cnt[dt_i]++;
         if (&topic_word_cnt[tw_i]) e = 1'b1; else topic_word_cnt[tw_i]++;
         if (&topic_total[t]) e = 1'b1; else topic_total[t]++;
         if (&doc_total[d]) e = 1'b1; else doc_total[d]++;
      end else begin
         if (doc_topic_cnt[dt_i] == 0) e = 1'b1; else doc_topic_cnt[dt_i]--;
         if (topic_word_cnt[tw_i] == 0) e = 1'b1; else topic_word_cnt[tw_i]--;
         if (topic_total[t] == 0) e = 1'b1; else topic_total[t]--;
         if (doc_total[d] == 0) e = 1'b1; else doc_total[d]--;
      end
      return e;
   endfunction

   // Counts an add token; else draws the new topic from the collapsed Gibbs conditional.
   function automatic topic_result_type resample_topic(logic func, logic [9:0] d,
         logic [11:0] w, logic [5:0] t, logic [23:0] r);
      topic_result_type res;
      logic [47:0]  weights [64];
      logic [63:0]  a, b, den, total, thr, run;
      logic [127:0] num;
      int           kk;
      res.err = 1'b0;
      if (func == FUNC_ADD) begin
         res.err = change_counts(d, w, t, 1'b1);
         res.topic = t;
         return res;
      end
      res.err = change_counts(d, w, t, 1'b0);
      kk = (cfg_topics == 0) ? 1 : (cfg_topics > 64) ? 64 : cfg_topics;
      total = 0;
      for (int k = 0; k < kk; k++) begin
         a = {topic_word_cnt[k * 4096 + w], 8'h00} + cfg_beta;
         b = {doc_topic_cnt[d * 64 + k], 8'h00} + cfg_alpha;
         den = {topic_total[k], 8'h00} + 64'(cfg_vocab) * cfg_beta;
         num = (128'(a) * b) << 8;
         if (den == 0 || num >= (128'(den) << 48)) weights[k] = WEIGHT_SAT;
         else weights[k] = 48'(num / den);
         total += weights[k];
      end
      thr = (total >> 24) * r + (((total & 64'hFF_FFFF) * r) >> 24);
      res.topic = 6'(kk - 1);
      run = 0;
      for (int k = 0; k < kk; k++) begin
         run += weights[k];
         if (run > thr) begin
            res.topic = 6'(k);
            break;
         end
      end
      res.err |= change_counts(d, w, res.topic, 1'b1);
      return res;
   endfunction

   // Sends one token word; the sender runs in bursts with random gaps between them.
   task automatic send_token(logic func, logic [9:0] d, logic [11:0] w, logic [5:0] t,
                             logic [23:0] r);
      int               gap;
      topic_result_type res;
      token_type        tok;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {4'h0, r, t, w, d};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = resample_topic(func, d, w, t, r);
      expected_topics.insert(expected_topics.size(), res);
      if (func == FUNC_RESAMPLE) begin
         foreach (live_tokens[i])
            if (live_tokens[i].doc == d && live_tokens[i].word == w &&
                live_tokens[i].topic == t) begin
               live_tokens[i].topic = res.topic;
               break;
            end
      end else begin
         tok.doc = d;
         tok.word = w;
         tok.topic = t;
         live_tokens.insert(live_tokens.size(), tok);
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_topics.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TOPIC_COUNT: cfg_topics = value[6:0];
         CSR_ALPHA:       cfg_alpha = value;
         CSR_BETA:        cfg_beta = value;
         CSR_VOCAB:       cfg_vocab = value[12:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(logic [6:0] k, logic [15:0] al, logic [15:0] be,
                             logic [12:0] v);
      drain();
      write_reg(CSR_TOPIC_COUNT, {9'h0, k});
      write_reg(CSR_ALPHA, al);
      write_reg(CSR_BETA, be);
      write_reg(CSR_VOCAB, {3'h0, v});
   endtask

   task automatic test_field_extremes;
      stall_mode = 0;
      send_token(FUNC_ADD, 10'd0, 12'd0, 6'd0, 24'd0);
      send_token(FUNC_ADD, 10'd1023, 12'd4095, 6'd63, 24'hFFFFFF);
      send_token(FUNC_ADD, 10'd0, 12'd0, 6'd1, 24'h5A5A5A);
      send_token(FUNC_RESAMPLE, 10'd0, 12'd0, 6'd0, 24'd0);
      send_token(FUNC_RESAMPLE, 10'd0, 12'd0, 6'd1, 24'hFFFFFF);
      // Removing a token that was never counted saturates at zero.
      send_token(FUNC_RESAMPLE, 10'd77, 12'd300, 6'd9, 24'h800000);
      // Old topic beyond the active range still has its counts updated.
      send_token(FUNC_RESAMPLE, 10'd1023, 12'd4095, 6'd63, 24'h123456);
   endtask

   task automatic test_config_extremes;
      set_config(7'd0, 16'd1, 16'd1, 13'd1);
      send_token(FUNC_RESAMPLE, 10'd3, 12'd7, 6'd2, 24'h400000);
      set_config(7'd127, 16'hFFFF, 16'hFFFF, 13'd8191);
      send_token(FUNC_RESAMPLE, 10'd0, 12'd0, 6'd0, 24'hFFFFFF);
      send_token(FUNC_RESAMPLE, 10'd5, 12'd9, 6'd40, 24'd1);
      // A zero prior with no vocabulary gives zero denominators on empty topics.
      set_config(7'd4, 16'd1, 16'd0, 13'd0);
      send_token(FUNC_ADD, 10'd8, 12'd5, 6'd0, 24'd0);
      send_token(FUNC_ADD, 10'd8, 12'd5, 6'd1, 24'd0);
      send_token(FUNC_RESAMPLE, 10'd8, 12'd5, 6'd0, 24'h7FFFFF);
      // Zero beta, words absent from all topics: every weight is zero.
      set_config(7'd2, 16'd1, 16'd0, 13'd4096);
      send_token(FUNC_ADD, 10'd9, 12'd11, 6'd0, 24'd0);
      send_token(FUNC_ADD, 10'd9, 12'd11, 6'd1, 24'd0);
      send_token(FUNC_RESAMPLE, 10'd9, 12'd12, 6'd0, 24'h9ABCDE);
      send_token(FUNC_RESAMPLE, 10'd9, 12'd11, 6'd1, 24'd0);
      set_config(7'd64, 16'd128, 16'd26, 13'd4096);
      send_token(FUNC_RESAMPLE, 10'd9, 12'd11, 6'd0, 24'hFFFFFF);
   endtask

   task automatic test_random_sampling;
      int        pick;
      token_type tok;
      for (int phase = 0; phase < 7; phase++) begin
         set_config(7'($urandom_range(0, 5) == 0 ? $urandom_range(0, 127) :
                       $urandom_range(1, 8)),
                    16'($urandom_range(0, 1) ? $urandom_range(1, 512) : $urandom()),
                    16'($urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom()),
                    13'($urandom_range(0, 3) == 0 ? $urandom() :
                        $urandom_range(16, 4096)));
         stall_mode = phase % 3;
         for (int n = 0; n < 150; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0 || live_tokens.size() < 8) begin
               send_token(1'($urandom_range(0, 1)), 10'($urandom()), 12'($urandom()),
                          6'($urandom()), 24'($urandom()));
            end else if (pick < 4) begin
               send_token(FUNC_ADD, 10'($urandom_range(0, 15)), 12'($urandom_range(0, 31)),
                          6'($urandom_range(0, 7)), 24'($urandom()));
            end else begin
               tok = live_tokens[$urandom_range(0, live_tokens.size() - 1)];
               send_token(FUNC_RESAMPLE, tok.doc, tok.word, tok.topic, 24'($urandom()));
            end
         end
      end
   endtask

   initial begin
      cfg_topics = RST_TOPIC_COUNT;
      cfg_alpha = RST_ALPHA;
      cfg_beta = RST_BETA;
      cfg_vocab = RST_VOCAB;
      foreach (doc_topic_cnt[i]) doc_topic_cnt[i] = '0;
      foreach (topic_word_cnt[i]) topic_word_cnt[i] = '0;
      foreach (topic_total[i]) topic_total[i] = '0;
      foreach (doc_total[i]) doc_total[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_config_extremes();
      test_random_sampling();
      drain();
      repeat (50) @(posedge clock);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
